// ===== src/fltu_pkg.sv =====
`default_nettype none
package fltu_pkg;
  localparam int unsigned TableFramesDef = 64;
  localparam int unsigned Levels = 4;
  localparam int unsigned EntryW = 45;
  localparam int unsigned PpnW = 40;
  localparam int unsigned IdxW = 9;

  localparam logic [2:0] OpMap   = 3'd0;
  localparam logic [2:0] OpTrans = 3'd1;
  localparam logic [2:0] OpRead  = 3'd2;
  localparam logic [2:0] OpWrite = 3'd3;
  localparam logic [2:0] OpSet   = 3'd4;
  localparam logic [2:0] OpClr   = 3'd5;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StVaUnal = 3'd1;
  localparam logic [2:0] StPaUnal = 3'd2;
  localparam logic [2:0] StNoMap  = 3'd3;
  localparam logic [2:0] StNoFree = 3'd4;

  // Datapath commands from the controller.
  typedef struct packed {
    logic       load;      // capture input transaction
    logic       rd;        // issue store read at walk address
    logic       step;      // follow read entry to next level
    logic       clr_wr;    // write zero at clear address
    logic       clr_inc;   // advance clear index
    logic       link_wr;   // link fresh frame at current slot
    logic       leaf_wr;   // write the updated leaf entry
    logic       res_load;  // capture result
    logic [2:0] res_st;
    logic       res_zero;
  } fltu_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       va_unal;
    logic       pa_unal;
    logic       ent_ok;     // read entry present and names a frame in range
    logic       ent_pres;
    logic       clr_last;
    logic       lvl_leaf;   // level counter reached the leaf table
    logic       no_free;    // not enough frames for the missing levels
  } fltu_sts_t;
endpackage
`default_nettype wire

// ===== src/fltu_datapath.sv =====
`default_nettype none
module fltu_datapath import fltu_pkg::*; #(
  parameter int unsigned TableFrames = TableFramesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire fltu_cmd_t   cmd_i,
  output fltu_sts_t        sts_o,
  input  wire logic [106:0] in_i,
  output logic [58:0]      res_o
);
  localparam int unsigned FrW = (TableFrames > 1) ? $clog2(TableFrames) : 1;
  localparam int unsigned AdW = FrW + IdxW;
  localparam int unsigned CntW = $clog2(TableFrames + 1);

  logic [EntryW-1:0] mem_q [TableFrames*512];
  logic [EntryW-1:0] rd_q;
  logic [2:0]  op_q;
  logic [47:0] va_q;
  logic [51:0] pa_q;
  logic [3:0]  pb_q;
  logic [FrW-1:0] frame_q, fresh_q;
  logic [1:0]  lvl_q;
  logic [IdxW-1:0] clr_q;
  logic [CntW-1:0] nff_q;
  logic        root_clr_q;
  logic [58:0] res_q;

  logic [IdxW-1:0] idx;
  logic [AdW-1:0]  slot, clr_addr;
  logic [39:0]     ppn;
  logic [3:0]      p, perm_old;
  logic [EntryW-1:0] leaf;
  logic [CntW-1:0] needed;

  always_comb begin
    unique case (lvl_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end
  assign slot = {frame_q, idx};
  assign clr_addr = {fresh_q, clr_q};
  assign ppn = rd_q[44:5];
  assign perm_old = rd_q[4:1];
  assign needed = CntW'(2'd3 - lvl_q);

  always_comb begin
    unique case (op_q)
      OpWrite: p = pb_q;
      OpSet:   p = perm_old | pb_q;
      OpClr:   p = perm_old & ~pb_q;
      default: p = perm_old;
    endcase
    if (op_q == OpMap) leaf = {pa_q[51:12], perm_old[3:1], 2'b11};
    else               leaf = {ppn, p, rd_q[0]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= (root_clr_q && frame_q == '0) ? '0 : mem_q[slot];
    if (cmd_i.clr_wr) mem_q[clr_addr] <= '0;
    else if (cmd_i.link_wr)
      mem_q[slot] <= {PpnW'(fresh_q), 3'b000, 2'b11};
    else if (cmd_i.leaf_wr) mem_q[slot] <= leaf;
    if (cmd_i.load) begin
      op_q <= in_i[2:0]; va_q <= in_i[50:3];
      pa_q <= in_i[102:51]; pb_q <= in_i[106:103];
    end
    if (cmd_i.res_load)
      res_q <= cmd_i.res_zero ? {cmd_i.res_st, 56'd0}
             : {cmd_i.res_st, leaf[4:1], leaf[44:5], va_q[11:0]};
  end

  // Hold root reads at zero until the first root write; the reset sweep clears
  // the root frame as well.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0; fresh_q <= '0; lvl_q <= '0; clr_q <= '0;
      nff_q <= CntW'(1); root_clr_q <= 1'b1;
    end else begin
      if (cmd_i.load) begin
        frame_q <= '0; lvl_q <= '0;
      end
      if (cmd_i.step) begin
        frame_q <= FrW'(ppn); lvl_q <= lvl_q + 2'd1;
      end
      if (cmd_i.clr_inc) clr_q <= clr_q + 1'b1;
      if (cmd_i.link_wr) begin
        frame_q <= fresh_q; lvl_q <= lvl_q + 2'd1;
        nff_q <= nff_q + 1'b1; fresh_q <= FrW'(nff_q + 1'b1);
      end
      if (cmd_i.load) fresh_q <= FrW'(nff_q);
      if ((cmd_i.link_wr || cmd_i.leaf_wr) && frame_q == '0) root_clr_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.op = op_q;
    sts_o.va_unal = |va_q[11:0];
    sts_o.pa_unal = |pa_q[11:0];
    sts_o.ent_pres = rd_q[0];
    sts_o.ent_ok = rd_q[0] && (ppn < 40'(TableFrames));
    sts_o.clr_last = &clr_q;
    sts_o.lvl_leaf = (lvl_q == 2'd3);
    sts_o.no_free = (nff_q > CntW'(TableFrames)) ||
                    (needed > CntW'(TableFrames) - nff_q);
  end
  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== src/fltu_ctrl.sv =====
`default_nettype none
module fltu_ctrl import fltu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire logic      root_done_i,
  output logic           root_clr_o,
  output logic [8:0]     root_idx_o,
  output fltu_cmd_t      cmd_o,
  input  wire fltu_sts_t sts_i
);
  localparam logic [3:0] SRoot = 4'd0, SIdle = 4'd1, SRd = 4'd2, SChk = 4'd3,
                         SClr = 4'd4, SLink = 4'd5, SLeafRd = 4'd6, SLeaf = 4'd7,
                         SOut = 4'd8;
  logic [3:0] st_q, st_d;
  logic [8:0] ri_q;
  logic       ov_q;

  assign in_ready_o = (st_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign root_clr_o = (st_q == SRoot);
  assign root_idx_o = ri_q;

  always_comb begin
    cmd_o = '0;
    st_d = st_q;
    unique case (st_q)
      SRoot: if (root_done_i) st_d = SIdle;
      SIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.load = 1'b1; st_d = SRd;
      end
      SRd: begin
        if (sts_i.op > OpClr) begin
          cmd_o.res_load = 1'b1; cmd_o.res_zero = 1'b1; cmd_o.res_st = StOk;
          st_d = SOut;
        end else begin
          cmd_o.rd = 1'b1; st_d = SChk;
        end
      end
      SChk: begin
        if (sts_i.ent_ok && !sts_i.lvl_leaf) begin
          cmd_o.step = 1'b1; st_d = SRd;
        end else if (sts_i.op == OpMap) begin
          cmd_o.res_load = 1'b1; cmd_o.res_zero = 1'b1;
          if (sts_i.va_unal) begin cmd_o.res_st = StVaUnal; st_d = SOut; end
          else if (sts_i.pa_unal) begin cmd_o.res_st = StPaUnal; st_d = SOut; end
          else if (sts_i.no_free) begin cmd_o.res_st = StNoFree; st_d = SOut; end
          else begin
            cmd_o.res_load = 1'b0;
            if (sts_i.lvl_leaf) st_d = SLeaf; else st_d = SClr;
          end
        end else if (!sts_i.lvl_leaf || !sts_i.ent_pres) begin
          cmd_o.res_load = 1'b1; cmd_o.res_zero = 1'b1; cmd_o.res_st = StNoMap;
          st_d = SOut;
        end else st_d = SLeaf;
      end
      SClr: begin
        cmd_o.clr_wr = 1'b1; cmd_o.clr_inc = 1'b1;
        if (sts_i.clr_last) st_d = SLink;
      end
      SLink: begin
        cmd_o.link_wr = 1'b1; st_d = SLeafRd;
      end
      SLeafRd: begin
        cmd_o.rd = 1'b1;
        if (sts_i.lvl_leaf) st_d = SLeaf; else st_d = SClr;
      end
      SLeaf: begin
        cmd_o.leaf_wr = (sts_i.op == OpMap) || (sts_i.op >= OpWrite);
        cmd_o.res_load = 1'b1; cmd_o.res_st = StOk;
        st_d = SOut;
      end
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SRoot; ri_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == SRoot) ri_q <= ri_q + 1'b1;
      if (st_q == SOut) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== src/four_level_page_table_unit.sv =====
`default_nettype none
// Four-level page table unit. After reset the root frame is swept clear, one
// entry a cycle, during which s_axis_tready stays low. Each transaction then
// makes up to 4 level reads through one store port; a map that allocates new
// frames adds a clear sweep for each new frame, all through the single store
// write port.
module four_level_page_table_unit import fltu_pkg::*; #(
  parameter int unsigned TableFrames = TableFramesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // operation[2:0], virtual_address[50:3], physical_address[102:51],
  // permission_bits[106:103], zero fill
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // translated_address[51:0], permissions_out[55:52], status[58:56], zero fill
  output logic [63:0]       m_axis_tdata
);
  fltu_cmd_t cmd, cmd_dp;
  fltu_sts_t sts;
  logic      root_clr;
  logic [8:0] root_idx;
  logic [58:0] res;

  fltu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .root_done_i(&root_idx), .root_clr_o(root_clr), .root_idx_o(root_idx),
    .cmd_o(cmd), .sts_i(sts)
  );

  // Root sweep reuses the clear path: fresh frame is 0 at reset, clear index runs.
  always_comb begin
    cmd_dp = cmd;
    if (root_clr) begin
      cmd_dp.clr_wr = 1'b1; cmd_dp.clr_inc = 1'b1;
    end
  end

  fltu_datapath #(.TableFrames(TableFrames)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd_dp), .sts_o(sts),
    .in_i(s_axis_tdata[106:0]), .res_o(res)
  );
  assign m_axis_tdata = {5'd0, res};

  // Drop input while a result waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[58:56] <= StNoFree) else $error("bad status");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[58:56] != StOk) |-> m_axis_tdata[55:0] == '0)
    else $error("error result not zero");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
  import fltu_pkg::*;

  localparam int unsigned NumFrames = TableFramesDef;
  localparam int unsigned NumEntries = 512;

  typedef struct packed {
    logic [3:0]  perms;
    logic [51:0] pa;
    logic [47:0] va;
    logic [2:0]  op;
  } walk_req_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [3:0]  perms;
    logic [51:0] xlat;
  } walk_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  four_level_page_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table frames; each entry is 45 bits as in the block.
  logic [44:0] shadow_pt [NumFrames*NumEntries];
  int unsigned next_frame;
  walk_rsp_t   pending_rsp [$];
  int unsigned mismatches;
  int unsigned sent_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off;
  bit          late_pages;
  logic [47:0] mapped_va [$];

  function automatic logic [8:0] lvl_idx(logic [47:0] va, int lvl);
    return va[12 + 9*(3-lvl) +: 9];
  endfunction

  // Predict one transaction and update the shadow table.
  function automatic walk_rsp_t predict_walk(walk_req_t r);
    walk_rsp_t   rsp;
    int unsigned frame;
    int          lvl;
    int unsigned slot;
    int unsigned fresh;
    logic [44:0] e;
    logic [3:0]  p;
    rsp = '0;
    if (r.op > OpClr) return rsp;
    frame = 0;
    lvl = 0;
    while (lvl < 3) begin
      e = shadow_pt[frame*NumEntries + lvl_idx(r.va, lvl)];
      if (!e[0] || e[44:5] >= NumFrames) break;
      frame = 32'(e[44:5]);
      lvl++;
    end
    if (r.op == OpMap) begin
      if (r.va[11:0] != 0) begin rsp.st = StVaUnal; return rsp; end
      if (r.pa[11:0] != 0) begin rsp.st = StPaUnal; return rsp; end
      if (next_frame > NumFrames || (3 - lvl) > NumFrames - next_frame) begin
        rsp.st = StNoFree;
        return rsp;
      end
      while (lvl < 3) begin
        fresh = next_frame++;
        for (int i = 0; i < NumEntries; i++) shadow_pt[fresh*NumEntries + i] = '0;
        shadow_pt[frame*NumEntries + lvl_idx(r.va, lvl)] = {40'(fresh), 5'b00011};
        frame = fresh;
        lvl++;
      end
      slot = frame*NumEntries + lvl_idx(r.va, 3);
      e = shadow_pt[slot];
      e = {r.pa[51:12], e[4:2], 2'b11};
      shadow_pt[slot] = e;
    end else begin
      if (lvl < 3) begin rsp.st = StNoMap; return rsp; end
      slot = frame*NumEntries + lvl_idx(r.va, 3);
      e = shadow_pt[slot];
      if (!e[0]) begin rsp.st = StNoMap; return rsp; end
      p = e[4:1];
      case (r.op)
        OpWrite: p = r.perms;
        OpSet:   p = p | r.perms;
        OpClr:   p = p & ~r.perms;
        default: ;
      endcase
      if (r.op >= OpWrite) begin
        e[4:1] = p;
        shadow_pt[slot] = e;
      end
    end
    rsp.xlat  = {e[44:5], r.va[11:0]};
    rsp.perms = e[4:1];
    rsp.st    = StOk;
    return rsp;
  endfunction

  // Offer one transaction, with a random idle gap first; predict on acceptance.
  // Valid stays high after acceptance until the next idle cycle, item or drain.
  task automatic send_req(walk_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {5'h0, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_rsp.push_back(predict_walk(r));
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  function automatic walk_req_t mk(logic [2:0] op, logic [47:0] va, logic [51:0] pa,
                                   logic [3:0] pb);
    walk_req_t r;
    r.op = op;
    r.va = va;
    r.pa = pa;
    r.perms = pb;
    return r;
  endfunction

  // Pick a virtual address: mostly near earlier mappings so walks go deep.
  function automatic logic [47:0] pick_va();
    logic [47:0] va;
    va = 48'({$urandom, $urandom});
    if (mapped_va.size() != 0 && $urandom_range(99) < 75) begin
      va = mapped_va[$urandom_range(mapped_va.size()-1)];
      case ($urandom_range(3))
        0: va[11:0] = 12'($urandom);
        1: va[20:12] = 9'($urandom);
        default: ;
      endcase
    end
    return va;
  endfunction

  // Receiver: stall at random, honour any requested hold-off, check results.
  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    walk_rsp_t got;
    walk_rsp_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[58:0];
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: xlat exp %h got %h, perms exp %h got %h, st exp %0d got %0d",
                     want.xlat, got.xlat, want.perms, got.perms, want.st, got.st);
        end
      end
    end
  end

  task automatic test_directed();
    send_req(mk(OpTrans, 48'h0, 52'h0, 4'h0));
    send_req(mk(OpRead, 48'hFFFF_FFFF_FFFF, 52'h0, 4'hF));
    send_req(mk(OpMap, 48'h1001, 52'h5000, 4'h0));
    send_req(mk(OpMap, 48'h1000, 52'h5FFF, 4'h0));
    send_req(mk(OpMap, 48'h0, 52'h0, 4'h0));
    send_req(mk(OpMap, 48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 4'hF));
    send_req(mk(OpTrans, 48'hFFFF_FFFF_FFFF, 52'h0, 4'h0));
    send_req(mk(OpTrans, 48'h0000_0000_0ABC, 52'h0, 4'h0));
    send_req(mk(OpWrite, 48'h0, 52'h0, 4'hF));
    send_req(mk(OpClr, 48'h0, 52'h0, 4'h5));
    send_req(mk(OpSet, 48'h0, 52'h0, 4'h8));
    send_req(mk(OpRead, 48'h0, 52'h0, 4'h0));
    send_req(mk(OpMap, 48'h0, 52'hA_5A5A_5A5A_5000, 4'h0));  // remap keeps user bits
    send_req(mk(OpRead, 48'h1000, 52'h0, 4'h0));          // leaf not present
    send_req(mk(OpWrite, 48'h8000_0000_0000, 52'h0, 4'h3)); // missing upper level
    send_req(mk(3'd6, 48'h0, 52'h0, 4'hF));
    send_req(mk(3'd7, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 4'hF));
    mapped_va.push_back(48'h0);
    mapped_va.push_back(48'hFFFF_FFFF_F000);
    drain();
  endtask

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    walk_req_t r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      r = mk(3'($urandom_range(5)), pick_va(), 52'({$urandom, $urandom}), 4'($urandom));
      case ($urandom_range(19))
        0: r.op = 3'($urandom_range(7));
        1, 2, 3: ;
        default: r.pa[11:0] = '0;
      endcase
      if (r.op == OpMap) begin
        // Keep frame use sparse until late so exhaustion comes near the end.
        if (!late_pages && $urandom_range(9) != 0 && mapped_va.size() != 0)
          r.va = mapped_va[$urandom_range(mapped_va.size()-1)];
        if ($urandom_range(9) != 0) r.va[11:0] = '0;
        if (r.va[11:0] == 0 && r.pa[11:0] == 0) mapped_va.push_back(r.va);
      end
      send_req(r);
    end
    drain();
  endtask

  // Hold the receiver off long enough that the block stalls its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 400;
    repeat (6) send_req(mk(OpTrans, pick_va(), 52'h0, 4'h0));
    drain();
  endtask

  initial begin
    mismatches = 0;
    sent_cnt = 0;
    next_frame = 1;
    hold_off = 0;
    late_pages = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NumEntries; i++) shadow_pt[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(500, 0, 0);
    test_backpressure();
    test_random(500, 53, 0);
    test_random(400, 0, 53);
    late_pages = 1;
    test_random(600, 35, 35);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Worst case: every map clearing three frames plus full stalls; ample margin.
  initial begin
    #40_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/fltu_pkg.sv
src/fltu_datapath.sv
src/fltu_ctrl.sv
src/four_level_page_table_unit.sv
dv/tb_top.sv
